>>> rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW encoder package
// Shared constants and types for the LZW byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none
package lzw_pkg;
  localparam int DefCodeWidth = 10;
  localparam int FirstFree    = 256;
  localparam int QueueDepth   = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;
endpackage
`default_nettype wire

>>> rtl/lzw_if.sv
// ----------------------------------------------------------------------------
// LZW stream interfaces
// Valid/ready channels for input bytes and emitted codes.
// ----------------------------------------------------------------------------
`default_nettype none
interface lzw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface lzw_out_if #(parameter int CODE_WIDTH = 10);
  logic                  valid;
  logic                  ready;
  logic [CODE_WIDTH-1:0] code_word;
  logic                  final_code;
  logic                  dictionary_full;
  modport source (output valid, code_word, final_code, dictionary_full, input ready);
  modport sink   (input valid, code_word, final_code, dictionary_full, output ready);
endinterface
`default_nettype wire

>>> rtl/lzw_front.sv
// ----------------------------------------------------------------------------
// LZW front end
// Accepts input items into a short queue that feeds the dictionary engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_front (
  input  wire logic             clk,
  input  wire logic             rst,
  lzw_in_if.sink                in_ch,
  output lzw_pkg::in_item_t     item,
  output logic                  item_valid,
  input  wire logic             item_take
);
  import lzw_pkg::*;

  in_item_t   q [QueueDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ch.ready = (count != 2'(QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = item_valid && item_take;
  assign item_valid = (count != 2'd0);
  assign item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{data_byte: in_ch.data_byte, end_of_data: in_ch.end_of_data};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/lzw_engine.sv
// ----------------------------------------------------------------------------
// LZW dictionary engine
// Searches the dictionary one entry at a time, inserts on a miss and emits codes.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_engine #(
  parameter int CODE_WIDTH = lzw_pkg::DefCodeWidth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lzw_pkg::in_item_t item,
  input  wire logic           item_valid,
  output logic                item_take,
  lzw_out_if.source           out_ch
);
  import lzw_pkg::*;

  localparam int Depth   = (1 << CODE_WIDTH) - FirstFree;
  localparam int IdxW    = CODE_WIDTH;
  localparam int EntryW  = CODE_WIDTH + 8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state;
  logic [EntryW-1:0]     mem [Depth];
  logic [EntryW-1:0]     rd_data;
  logic [IdxW-1:0]       idx;
  logic [CODE_WIDTH-1:0] prefix_code;
  logic                  prefix_present;
  logic [CODE_WIDTH:0]   next_free_code;
  logic [7:0]            cur_byte;
  logic                  cur_eod;
  logic [EntryW-1:0]     key;
  logic [CODE_WIDTH:0]   used;
  logic                  full;
  logic                  mem_we;
  logic                  init_we;
  logic                  obusy;
  logic                  emit;

  assign used  = next_free_code - (CODE_WIDTH+1)'(FirstFree);
  assign full  = next_free_code[CODE_WIDTH];
  assign key   = {prefix_code, cur_byte};
  assign obusy = out_ch.valid && !out_ch.ready;
  assign emit  = ((state == S_EMIT) || (state == S_FINAL)) && !obusy;
  assign item_take = (state == S_IDLE) && item_valid;
  assign mem_we = (state == S_CMP) && !(rd_data == key) &&
                  ((CODE_WIDTH+1)'(idx) + 1'b1 >= used) && !full;
  // A fresh dictionary insert with an empty store writes entry zero.
  assign init_we = (state == S_IDLE) && item_valid && prefix_present &&
                   (next_free_code == (CODE_WIDTH+1)'(FirstFree));

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (mem_we) begin
      mem[used[IdxW-1:0]] <= key;
    end else if (init_we) begin
      mem[0] <= {prefix_code, item.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      prefix_present <= 1'b0;
      prefix_code    <= '0;
      next_free_code <= (CODE_WIDTH+1)'(FirstFree);
      out_ch.valid   <= 1'b0;
      idx            <= '0;
    end else begin
      if (emit) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_byte <= item.data_byte;
            cur_eod  <= item.end_of_data;
            idx      <= '0;
            if (!prefix_present) begin
              prefix_code    <= CODE_WIDTH'(item.data_byte);
              prefix_present <= 1'b1;
              state <= item.end_of_data ? S_FINAL : S_IDLE;
            end else if (next_free_code == (CODE_WIDTH+1)'(FirstFree)) begin
              // Empty dictionary: the insert of the miss is made here directly.
              state <= S_EMIT;
              if (!full) next_free_code <= next_free_code + 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (rd_data == key) begin
            prefix_code <= CODE_WIDTH'((CODE_WIDTH+1)'(idx) + (CODE_WIDTH+1)'(FirstFree));
            state <= cur_eod ? S_FINAL : S_IDLE;
          end else if ((CODE_WIDTH+1)'(idx) + 1'b1 >= used) begin
            if (!full) next_free_code <= next_free_code + 1'b1;
            state <= S_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (!obusy) begin
            out_ch.code_word       <= prefix_code;
            out_ch.final_code      <= 1'b0;
            out_ch.dictionary_full <= full;
            prefix_code <= CODE_WIDTH'(cur_byte);
            state <= cur_eod ? S_FINAL : S_IDLE;
          end
        end
        S_FINAL: begin
          if (!obusy) begin
            out_ch.code_word       <= prefix_code;
            out_ch.final_code      <= 1'b1;
            out_ch.dictionary_full <= full;
            prefix_code    <= '0;
            prefix_present <= 1'b0;
            next_free_code <= (CODE_WIDTH+1)'(FirstFree);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/lzw_byte_encoder.sv
// A byte is registered in the input queue; the engine then accepts it in S_IDLE,
// reads and compares each dictionary entry searched (S_READ, S_CMP), registers
// a code on a miss (S_EMIT) and the final code on a stream's last byte (S_FINAL).
// A stream's first byte needs only the accepting state. The engine takes no new
// byte until the last one's search is done, and a stalled output holds it.
// Reset (synchronous) empties the prefix, restarts codes at 256 and clears the queue.
// ----------------------------------------------------------------------------
// LZW byte encoder
// Front queue feeding a sequential dictionary search and insert engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_byte_encoder #(
  parameter int CODE_WIDTH = lzw_pkg::DefCodeWidth
) (
  input  wire logic clk,
  input  wire logic rst,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch
);
  import lzw_pkg::*;

  in_item_t item;
  logic     item_valid, item_take;

  lzw_front u_front (
    .clk, .rst, .in_ch, .item, .item_valid, .item_take
  );

  lzw_engine #(.CODE_WIDTH(CODE_WIDTH)) u_engine (
    .clk, .rst, .item, .item_valid, .item_take, .out_ch
  );
endmodule
`default_nettype wire

>>> rtl/lzw_checker.sv
// ----------------------------------------------------------------------------
// LZW encoder checker
// Port-level checks on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_checker #(
  parameter int CODE_WIDTH = 10
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [CODE_WIDTH-1:0] code_word,
  input wire logic                  final_code,
  input wire logic                  dictionary_full
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_word)) else $error("stall");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && final_code |=> !(out_valid && dictionary_full))
    else $error("dictionary not cleared");
endmodule

bind lzw_byte_encoder lzw_checker #(.CODE_WIDTH(CODE_WIDTH)) u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .code_word(out_ch.code_word), .final_code(out_ch.final_code),
  .dictionary_full(out_ch.dictionary_full)
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW byte encoder testbench
// Drives byte streams through the encoder with random idling on both
// channels and checks every emitted code against a built-in dictionary model.
// ----------------------------------------------------------------------------
module tb_top;
  import lzw_pkg::*;

  localparam int CodeWidth = DefCodeWidth;
  localparam int CodeLimit = 1 << CodeWidth;
  localparam int StoreDepth = CodeLimit - FirstFree;
  localparam int DrainCycles = 2 * StoreDepth + 50;
  localparam longint CycleLimit = 20000000;
  localparam int IdlePct = 21;

  typedef struct {
    logic [CodeWidth-1:0] code_word;
    bit                   final_code;
    bit                   dictionary_full;
  } code_item_t;

  typedef struct {
    logic [7:0]           data_byte;
    bit                   end_of_data;
    bit                   has_code;
    logic [CodeWidth-1:0] code_word;
  } stim_row_t;

  logic clk;
  logic rst;

  lzw_in_if                             in_ch();
  lzw_out_if #(.CODE_WIDTH(CodeWidth))  out_ch();

  lzw_byte_encoder #(.CODE_WIDTH(CodeWidth)) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Dictionary model state
  logic [CodeWidth-1:0] cur_prefix;
  bit                   prefix_held;
  logic [CodeWidth:0]   next_code;
  logic [CodeWidth+7:0] pair_store [StoreDepth];

  code_item_t pending_codes[$];
  int  mismatches;
  int  codes_seen;
  int  full_codes_seen;
  int  streams_sent;
  int  bytes_sent;
  bit  calm;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes pending", cycles, pending_codes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  function automatic void push_code(input logic [CodeWidth-1:0] code, input bit fin);
    code_item_t c;
    c.code_word = code;
    c.final_code = fin;
    c.dictionary_full = (next_code >= CodeLimit);
    pending_codes.insert(pending_codes.size(), c);
  endfunction

  // Works out the codes caused by one accepted byte and updates the dictionary.
  function automatic void encode_byte(input logic [7:0] b, input bit eod);
    logic [CodeWidth+7:0] key;
    int used;
    int hit_idx;
    hit_idx = -1;
    if (!prefix_held) begin
      cur_prefix = CodeWidth'(b);
      prefix_held = 1'b1;
    end else begin
      key = {cur_prefix, b};
      used = int'(next_code) - FirstFree;
      for (int i = 0; i < used; i++) begin
        if (pair_store[i] == key) begin
          hit_idx = i;
          break;
        end
      end
      if (hit_idx >= 0) begin
        cur_prefix = CodeWidth'(FirstFree + hit_idx);
      end else begin
        if (next_code < CodeLimit) begin
          pair_store[int'(next_code) - FirstFree] = key;
          next_code++;
        end
        push_code(cur_prefix, 1'b0);
        cur_prefix = CodeWidth'(b);
      end
    end
    if (eod) begin
      push_code(cur_prefix, 1'b1);
      cur_prefix = '0;
      prefix_held = 1'b0;
      next_code = (CodeWidth+1)'(FirstFree);
    end
  endfunction

  // Receiver: ready changes at the rising edge, the result is taken mid-cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(negedge clk) begin
    code_item_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      codes_seen++;
      if (out_ch.dictionary_full) full_codes_seen++;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected code %0d", out_ch.code_word));
      end else begin
        e = pending_codes.pop_front();
        if (out_ch.code_word !== e.code_word)
          report($sformatf("code_word %0d, expected %0d", out_ch.code_word, e.code_word));
        if (out_ch.final_code !== e.final_code)
          report($sformatf("final_code %0b, expected %0b", out_ch.final_code, e.final_code));
        if (out_ch.dictionary_full !== e.dictionary_full)
          report($sformatf("dictionary_full %0b, expected %0b",
                           out_ch.dictionary_full, e.dictionary_full));
      end
    end
  end

  // Presents one item and returns once it has been accepted; valid stays high.
  task automatic send_byte(input logic [7:0] b, input bit eod);
    bit took;
    if (!calm && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_data <= eod;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    encode_byte(b, eod);
    bytes_sent++;
    if (eod) streams_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  stim_row_t directed[$];

  function automatic void add_row(input logic [7:0] b, input bit eod, input bit has,
                                  input logic [CodeWidth-1:0] code);
    stim_row_t r;
    r.data_byte = b;
    r.end_of_data = eod;
    r.has_code = has;
    r.code_word = code;
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    int n;
    int len;
    int alpha;
    cycles = 0;
    mismatches = 0;
    codes_seen = 0;
    full_codes_seen = 0;
    streams_sent = 0;
    bytes_sent = 0;
    calm = 1'b0;
    cur_prefix = '0;
    prefix_held = 1'b0;
    next_code = (CodeWidth+1)'(FirstFree);
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_data = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-byte streams, a repeated byte, alternating pairs at the extremes.
    add_row(8'h00, 1'b1, 1'b1, 0);
    add_row(8'hFF, 1'b1, 1'b1, 255);
    repeat (4) add_row(8'h41, 1'b0, 1'b0, 0);
    add_row(8'h41, 1'b1, 1'b0, 0);
    for (int i = 0; i < 6; i++) add_row(i[0] ? 8'h01 : 8'h80, i == 5, 1'b0, 0);
    for (int i = 0; i < 7; i++) add_row(i[0] ? 8'hFF : 8'h00, i == 6, 1'b0, 0);
    add_row(8'h7F, 1'b1, 1'b1, 127);

    foreach (directed[i]) begin
      send_byte(directed[i].data_byte, directed[i].end_of_data);
      if (directed[i].has_code && pending_codes[$].code_word !== directed[i].code_word)
        report($sformatf("row %0d: model gives %0d, table says %0d",
                         i, pending_codes[$].code_word, directed[i].code_word));
    end

    // Short streams, mostly over narrow alphabets, so that matches and chains occur.
    n = 0;
    while (n < 850) begin
      len = $urandom_range(1, 40);
      alpha = $urandom_range(0, 3);
      calm = (n > 300 && n < 450);
      for (int k = 0; k < len; k++) begin
        logic [7:0] b;
        case (alpha)
          0: b = 8'(8'h61 + $urandom_range(0, 1));
          1: b = 8'(8'hF0 + $urandom_range(0, 3));
          2: b = 8'($urandom_range(0, 255));
          default: b = (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF) ^ 8'($urandom_range(0, 1));
        endcase
        send_byte(b, k == len - 1);
        n++;
      end
    end
    calm = 1'b0;

    // Hold the sender until the encoder has emitted everything owed.
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    // One long stream of wide-range bytes fills the dictionary and runs on past it.
    for (int k = 0; k < 920; k++) send_byte(8'($urandom_range(0, 255)), k == 919);
    for (int k = 0; k < 12; k++) send_byte(8'($urandom_range(0, 3)), k == 11);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d streams, checked %0d codes (%0d with the dictionary full)",
             bytes_sent, streams_sent, codes_seen, full_codes_seen);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d codes missing", mismatches, pending_codes.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
